FILE: design/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants for the temperature to sound speed pipeline.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int TEMP_W        = 16;
    localparam int REG_W         = 17;
    localparam int SPEED_W       = 18;
    localparam int OUT_DATA_W    = 24;
    localparam int REG_FRAC_BITS = 8;
    localparam int B_W           = 16;
    localparam int SQ_W          = 2 * REG_W;
    localparam int PROD_W        = SQ_W + B_W;
    localparam int ROOT_BITS     = 20;
    localparam int REM_W         = 53;
    localparam int P_W           = 33;
    localparam int TRIAL_W       = REM_W + 1;

    localparam logic [B_W-1:0]   ZERO_C    = 16'd4368;
    localparam logic [REG_W-1:0] REG_RESET = 17'd84851;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [P_W-1:0]       p;
        logic [ROOT_BITS-1:0] y;
        logic                 clamped;
    } t_root;

endpackage

FILE: design/temperature_to_sound_speed.sv
// ----------------------------------------------------------------------------
// temperature_to_sound_speed
// Speed of sound from a thermometer word through a pipelined square root.
// ----------------------------------------------------------------------------
// Accepts one temperature word per clock and returns one speed per clock
// while the sink keeps up. Three stages clamp the word and form the scaled
// radicand S^2 * (4368 + w), with a multiply in each of the first two;
// twenty stages resolve one root bit each, and one stage scales, saturates
// and holds the result. Each stage has its own valid bit, so bubbles close
// up while the output waits. Write the speed-at-zero register only while no
// request is in flight.
module temperature_to_sound_speed #(
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tss_pkg::REG_W-1:0]     i_cfg_wdata,     // speed_at_zero_q8
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tss_pkg::TEMP_W-1:0]    i_s_tdata,       // temp_raw
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tss_pkg::OUT_DATA_W-1:0] o_m_tdata,      // speed_q8, zero pad
    output logic [0:0]                    o_m_tuser        // clamped
);

    localparam int UP_SHIFT   = (OUT_FRAC_BITS >= tss_pkg::REG_FRAC_BITS)
                              ? OUT_FRAC_BITS - tss_pkg::REG_FRAC_BITS : 0;
    localparam int DOWN_SHIFT = (OUT_FRAC_BITS >= tss_pkg::REG_FRAC_BITS)
                              ? 0 : tss_pkg::REG_FRAC_BITS - OUT_FRAC_BITS;
    localparam int ZS_W       = tss_pkg::REG_W + UP_SHIFT;

    logic [tss_pkg::REG_W-1:0]   r_speed_zero;
    tss_pkg::t_root              w_data  [tss_pkg::ROOT_BITS+1];
    logic                        w_valid [tss_pkg::ROOT_BITS+1];
    logic                        w_ready [tss_pkg::ROOT_BITS+1];
    logic [tss_pkg::SPEED_W-1:0] w_speed;
    logic                        w_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_zero <= tss_pkg::REG_RESET;
        end else if (i_cfg_we) begin
            r_speed_zero <= i_cfg_wdata;
        end
    end

    tss_prep #(
        .UP_SHIFT (UP_SHIFT)
    ) u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_speed_zero (r_speed_zero),
        .i_valid      (i_s_tvalid),
        .i_temp       (i_s_tdata),
        .o_ready      (o_s_tready),
        .o_valid      (w_valid[0]),
        .o_data       (w_data[0]),
        .i_ready      (w_ready[0])
    );

    for (genvar g = 0; g < tss_pkg::ROOT_BITS; g++) begin : g_root
        tss_root_step #(
            .K (tss_pkg::ROOT_BITS - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_ready (w_ready[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    tss_out #(
        .DOWN_SHIFT (DOWN_SHIFT)
    ) u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid[tss_pkg::ROOT_BITS]),
        .i_data    (w_data[tss_pkg::ROOT_BITS]),
        .o_ready   (w_ready[tss_pkg::ROOT_BITS]),
        .o_valid   (o_m_tvalid),
        .o_speed   (w_speed),
        .o_clamped (w_clamped),
        .i_ready   (i_m_tready)
    );

    assign o_m_tdata = tss_pkg::OUT_DATA_W'(w_speed);
    assign o_m_tuser = w_clamped;

    logic [ZS_W-1:0]             w_zs_full;
    logic [ZS_W-1:0]             w_zs_shift;
    logic [tss_pkg::SPEED_W-1:0] w_zs;

    assign w_zs_full  = ZS_W'(r_speed_zero) << UP_SHIFT;
    assign w_zs_shift = w_zs_full >> DOWN_SHIFT;
    assign w_zs       = (|(w_zs_shift >> tss_pkg::SPEED_W)) ? '1
                                                            : tss_pkg::SPEED_W'(w_zs_shift);

    a_clamp_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> w_speed == w_zs)
        else $error("clamped request does not give the speed at zero");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with an empty output register");

    a_sink_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input stalled while the sink takes results");

endmodule

FILE: design/tss_prep.sv
// ----------------------------------------------------------------------------
// tss_prep
// Clamp the temperature word, form S^2 * (4368 + w) scaled to the output
// precision, and saturate it into the radicand width. Three register stages.
// ----------------------------------------------------------------------------
module tss_prep #(
    parameter int UP_SHIFT = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tss_pkg::REG_W-1:0]   i_speed_zero,
    input  logic                        i_valid,
    input  logic [tss_pkg::TEMP_W-1:0]  i_temp,
    output logic                        o_ready,
    output logic                        o_valid,
    output tss_pkg::t_root              o_data,
    input  logic                        i_ready
);

    localparam int EXT_W = tss_pkg::PROD_W + 2 * UP_SHIFT;

    logic [tss_pkg::SQ_W-1:0]   r_sq;
    logic                       r_v0, r_v1, r_v2;
    logic [tss_pkg::B_W-1:0]    r_b;
    logic                       r_clamp0, r_clamp1;
    logic [tss_pkg::PROD_W-1:0] r_prod;
    tss_pkg::t_root             r_data;

    logic                       w_rdy0, w_rdy1, w_rdy2;
    logic                       w_sign;
    logic [tss_pkg::B_W-1:0]    n_b;
    logic [tss_pkg::PROD_W-1:0] n_prod;
    logic [EXT_W-1:0]           w_ext;
    logic                       w_sat;
    tss_pkg::t_root             n_data;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign w_rdy0  = !r_v0 || w_rdy1;
    assign o_ready = w_rdy0;
    assign o_valid = r_v2;
    assign o_data  = r_data;

    assign w_sign = i_temp[tss_pkg::TEMP_W-1];
    assign n_b    = w_sign ? tss_pkg::ZERO_C
                           : tss_pkg::ZERO_C + tss_pkg::B_W'(i_temp[tss_pkg::TEMP_W-2:0]);
    assign n_prod = tss_pkg::PROD_W'(r_sq) * tss_pkg::PROD_W'(r_b);

    assign w_ext = EXT_W'(r_prod) << (2 * UP_SHIFT);
    assign w_sat = |(w_ext >> tss_pkg::REM_W);

    always_comb begin
        n_data.rem     = w_sat ? '1 : tss_pkg::REM_W'(w_ext);
        n_data.p       = '0;
        n_data.y       = '0;
        n_data.clamped = r_clamp1;
    end

    always_ff @(posedge i_clk) begin
        r_sq <= tss_pkg::SQ_W'(i_speed_zero) * tss_pkg::SQ_W'(i_speed_zero);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy0) r_v0 <= i_valid;
            if (w_rdy1) r_v1 <= r_v0;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r_b      <= n_b;
            r_clamp0 <= w_sign;
        end
        if (w_rdy1 && r_v0) begin
            r_prod   <= n_prod;
            r_clamp1 <= r_clamp0;
        end
        if (w_rdy2 && r_v1) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: design/tss_root_step.sv
// ----------------------------------------------------------------------------
// tss_root_step
// One digit of the scaled square root: try root bit K against the remaining
// radicand, with 4368 * y kept alongside to avoid a multiply.
// ----------------------------------------------------------------------------
module tss_root_step #(
    parameter int K = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tss_pkg::t_root i_data,
    output logic           o_ready,
    output logic           o_valid,
    output tss_pkg::t_root o_data,
    input  logic           i_ready
);

    logic                        r_valid;
    tss_pkg::t_root              r_data;
    logic [tss_pkg::TRIAL_W-1:0] w_trial;
    logic                        w_take;
    tss_pkg::t_root              n_data;

    assign w_trial = (tss_pkg::TRIAL_W'(i_data.p) << (K + 1))
                   + (tss_pkg::TRIAL_W'(tss_pkg::ZERO_C) << (2 * K));
    assign w_take  = w_trial <= tss_pkg::TRIAL_W'(i_data.rem);

    always_comb begin
        n_data = i_data;
        if (w_take) begin
            n_data.rem = i_data.rem - tss_pkg::REM_W'(w_trial);
            n_data.p   = i_data.p + (tss_pkg::P_W'(tss_pkg::ZERO_C) << K);
            n_data.y   = i_data.y | (tss_pkg::ROOT_BITS'(1) << K);
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: design/tss_out.sv
// ----------------------------------------------------------------------------
// tss_out
// Scale the root down to the output precision, saturate, and hold the
// result in the output register.
// ----------------------------------------------------------------------------
module tss_out #(
    parameter int DOWN_SHIFT = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  tss_pkg::t_root              i_data,
    output logic                        o_ready,
    output logic                        o_valid,
    output logic [tss_pkg::SPEED_W-1:0] o_speed,
    output logic                        o_clamped,
    input  logic                        i_ready
);

    logic                          r_valid;
    logic [tss_pkg::SPEED_W-1:0]   r_speed;
    logic                          r_clamped;
    logic [tss_pkg::ROOT_BITS-1:0] w_shift;
    logic                          w_sat;
    logic [tss_pkg::SPEED_W-1:0]   n_speed;

    assign w_shift = i_data.y >> DOWN_SHIFT;
    assign w_sat   = |w_shift[tss_pkg::ROOT_BITS-1:tss_pkg::SPEED_W];
    assign n_speed = w_sat ? '1 : w_shift[tss_pkg::SPEED_W-1:0];

    assign o_ready   = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_speed   = r_speed;
    assign o_clamped = r_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_speed   <= n_speed;
            r_clamped <= i_data.clamped;
        end
    end

endmodule
